// ===== rtl/moc_pkg.sv =====
`timescale 1ns / 1ps

package moc_pkg;

    // Field widths of the channels and the configuration register.
    localparam int CMD_W    = 3;
    localparam int EXP_W    = 16;
    localparam int WEIGHT_W = 16;
    localparam int ORDER_W  = 39;
    localparam int DEG_W    = 24;
    localparam int LEAD_W   = 7;

    // Defaults for the top-level parameters.
    localparam int MAX_VARS_DEF  = 64;
    localparam int EXP_WIDTH_DEF = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LEX       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GRLEX     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WREVLEX   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIVIDES   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EQUAL     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REL_PRIME = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LCM       = 3'd6;

    // Lead variable after reset: none.
    localparam logic [LEAD_W-1:0] LEAD_NONE = '1;

endpackage

// ===== rtl/moc_if.sv =====
`timescale 1ns / 1ps

// Input channel: one exponent pair per transaction.
interface moc_in_if;
    import moc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [EXP_W-1:0]    first_exponent;
    logic [EXP_W-1:0]    second_exponent;
    logic [WEIGHT_W-1:0] variable_weight;
    logic                last_element;

    modport source (
        output valid, command, first_exponent, second_exponent,
               variable_weight, last_element,
        input  ready
    );
    modport sink (
        input  valid, command, first_exponent, second_exponent,
               variable_weight, last_element,
        output ready
    );
endinterface

// Result channel: zero or one result per input transaction.
interface moc_out_if;
    import moc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ORDER_W-1:0]  order;
    logic                       holds;
    logic [EXP_W-1:0]           lcm_exponent;
    logic                       last;

    modport source (
        output valid, order, holds, lcm_exponent, last,
        input  ready
    );
    modport sink (
        input  valid, order, holds, lcm_exponent, last,
        output ready
    );
endinterface

// ===== rtl/monomial_order_compare_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// i_in      sink       command, two exponents, weight and last flag of one variable
// o_out     source     order, holds, lcm exponent and last flag of one result
// i_cfg_*   write      lead variable for weighted reverse lex ties
//
// An input transaction is taken every cycle when neither stage is stalled.
// Each item passes through the input register and then, if it makes a result,
// into the result register, from which the result is offered.
// The multiply-accumulate of weight and difference sets the cycle time.
// Synchronous active-low reset clears both valid flags and the pair state.
// A stalled result holds and the input register waits behind it, whether
// or not its item makes a result, so i_in.ready drops only under a stall.
module monomial_order_compare_core #(
    parameter int MAX_VARS  = moc_pkg::MAX_VARS_DEF,
    parameter int EXP_WIDTH = moc_pkg::EXP_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [moc_pkg::LEAD_W-1:0] i_cfg_wdata,
    moc_in_if.sink                     i_in,
    moc_out_if.source                  o_out
);
    import moc_pkg::*;

    localparam int IdxW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int DiffW = EXP_WIDTH + 1;
    localparam int ProdW = WEIGHT_W + 1 + DiffW;

    // Configuration register.
    logic [LEAD_W-1:0] r_lead;

    // Input register.
    logic                 r_in_valid;
    logic [CMD_W-1:0]     r_in_cmd;
    logic [EXP_WIDTH-1:0] r_in_e1;
    logic [EXP_WIDTH-1:0] r_in_e2;
    logic [WEIGHT_W-1:0]  r_in_w;
    logic                 r_in_last;
    logic [LEAD_W-1:0]    r_in_lead;

    // Pair state.
    logic [IdxW-1:0]           r_idx;
    logic [CMD_W-1:0]          r_cmd;
    logic signed [ORDER_W-1:0] r_wsum;
    logic signed [DEG_W-1:0]   r_deg;
    logic signed [DiffW-1:0]   r_first;
    logic signed [DiffW-1:0]   r_latest;
    logic signed [DiffW-1:0]   r_leaddiff;
    logic                      r_div;
    logic                      r_eq;
    logic                      r_dis;

    // Result register.
    logic                      r_out_valid;
    logic signed [ORDER_W-1:0] r_order;
    logic                      r_holds;
    logic [EXP_W-1:0]          r_lcm;
    logic                      r_last;

    // Next values.
    logic [CMD_W-1:0]          n_cmd;
    logic signed [ORDER_W-1:0] n_wsum;
    logic signed [DEG_W-1:0]   n_deg;
    logic signed [DiffW-1:0]   n_first;
    logic signed [DiffW-1:0]   n_latest;
    logic signed [DiffW-1:0]   n_leaddiff;
    logic                      n_div;
    logic                      n_eq;
    logic                      n_dis;
    logic signed [ORDER_W-1:0] n_order;
    logic                      n_holds;
    logic [EXP_W-1:0]          n_lcm;

    logic signed [DiffW-1:0]   diff;
    logic signed [ProdW-1:0]   prod;
    logic                      item_last;
    logic                      lead_hit;
    logic                      emit;
    logic                      advance;
    logic                      in_ready;

    // Handshake: the input register moves on when the result register is free.
    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    // Per-item arithmetic and the accumulator updates.
    always_comb begin
        diff = $signed({1'b0, r_in_e1}) - $signed({1'b0, r_in_e2});
        prod = $signed({1'b0, r_in_w}) * diff;
        item_last = r_in_last || (r_idx == IdxW'(MAX_VARS - 1));
        lead_hit = !r_in_lead[LEAD_W-1]
                   && (r_in_lead[LEAD_W-2:0] == (LEAD_W - 1)'(r_idx));
        n_cmd = (r_idx == '0) ? r_in_cmd : r_cmd;

        n_wsum     = r_wsum + ORDER_W'(prod);
        n_deg      = r_deg + DEG_W'(diff);
        n_first    = (r_first == '0) ? diff : r_first;
        n_latest   = (diff != '0) ? diff : r_latest;
        n_leaddiff = lead_hit ? diff : r_leaddiff;
        n_div      = r_div && !(r_in_e1 > r_in_e2);
        n_eq       = r_eq && (diff == '0);
        n_dis      = r_dis && !((r_in_e1 != '0) && (r_in_e2 != '0));
    end

    // Result selection from the updated accumulators.
    always_comb begin
        n_order = '0;
        n_holds = 1'b0;
        n_lcm   = '0;
        emit    = item_last || (n_cmd == CMD_LCM);
        case (n_cmd)
            CMD_LEX: begin
                n_order = ORDER_W'(n_first);
            end
            CMD_GRLEX: begin
                n_order = (n_deg != '0) ? ORDER_W'(n_deg) : ORDER_W'(n_first);
            end
            CMD_WREVLEX: begin
                if (n_wsum != '0) begin
                    n_order = n_wsum;
                end else if (n_leaddiff != '0) begin
                    n_order = -ORDER_W'(n_leaddiff);
                end else begin
                    n_order = -ORDER_W'(n_latest);
                end
            end
            CMD_DIVIDES: begin
                n_holds = n_div;
            end
            CMD_EQUAL: begin
                n_holds = n_eq;
            end
            CMD_REL_PRIME: begin
                n_holds = n_dis;
            end
            CMD_LCM: begin
                n_lcm = EXP_W'((r_in_e1 >= r_in_e2) ? r_in_e1 : r_in_e2);
            end
            default: begin
                n_order = '0;
            end
        endcase
    end

    // Configuration and input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead     <= LEAD_NONE;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lead <= i_cfg_wdata;
            end
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
        end
        if (in_ready && i_in.valid) begin
            r_in_cmd  <= i_in.command;
            r_in_e1   <= i_in.first_exponent[EXP_WIDTH-1:0];
            r_in_e2   <= i_in.second_exponent[EXP_WIDTH-1:0];
            r_in_w    <= i_in.variable_weight;
            r_in_last <= i_in.last_element;
            r_in_lead <= r_lead;
        end
    end

    // Pair state: cleared after the final item of each pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && item_last)) begin
            r_idx      <= '0;
            r_cmd      <= CMD_LEX;
            r_wsum     <= '0;
            r_deg      <= '0;
            r_first    <= '0;
            r_latest   <= '0;
            r_leaddiff <= '0;
            r_div      <= 1'b1;
            r_eq       <= 1'b1;
            r_dis      <= 1'b1;
        end else if (advance) begin
            r_idx      <= r_idx + 1'b1;
            r_cmd      <= n_cmd;
            r_wsum     <= n_wsum;
            r_deg      <= n_deg;
            r_first    <= n_first;
            r_latest   <= n_latest;
            r_leaddiff <= n_leaddiff;
            r_div      <= n_div;
            r_eq       <= n_eq;
            r_dis      <= n_dis;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_order <= n_order;
            r_holds <= n_holds;
            r_lcm   <= n_lcm;
            r_last  <= item_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.order        = r_order;
    assign o_out.holds        = r_holds;
    assign o_out.lcm_exponent = r_lcm;
    assign o_out.last         = r_last;

endmodule

// ===== rtl/moc_checker.sv =====
`timescale 1ns / 1ps

module moc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [moc_pkg::ORDER_W-1:0] i_out_order,
    input logic                               i_out_holds,
    input logic [moc_pkg::EXP_W-1:0]          i_out_lcm,
    input logic                               i_out_last
);
    import moc_pkg::*;

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_order)
            && $stable(i_out_holds) && $stable(i_out_lcm) && $stable(i_out_last)))
        else $error("stalled result changed");

    // Reset empties the result register by the next edge.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A flag result never carries an order, and an order never a flag.
    a_order_or_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_holds && (i_out_order != '0)))
        else $error("order and flag both set");

    // Only lcm emits results before the last one, and those carry no order.
    a_mid_pair_lcm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> ((i_out_order == '0) && !i_out_holds))
        else $error("non-final result from a comparing command");

    // An lcm exponent excludes the other two fields.
    a_lcm_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_lcm != '0)) |-> ((i_out_order == '0) && !i_out_holds))
        else $error("lcm exponent alongside order or flag");

endmodule

bind monomial_order_compare_core moc_checker u_moc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_order (o_out.order),
    .i_out_holds (o_out.holds),
    .i_out_lcm   (o_out.lcm_exponent),
    .i_out_last  (o_out.last)
);
